// ===== design/gfr_pkg.sv =====
package gfr_pkg;

    // Sample width of each rate axis
    localparam int SAMPLE_WIDTH = 16;
    localparam int LEVEL_WIDTH  = 15;
    localparam int WINDOW_WIDTH = 8;
    localparam int FACE_WIDTH   = 3;
    localparam int CFG_WIDTH    = 15;
    localparam int CFG_IDX_W    = 2;
    // Comparison width wide enough for a magnitude and a level
    localparam int CMP_WIDTH    = (SAMPLE_WIDTH > LEVEL_WIDTH) ? SAMPLE_WIDTH : LEVEL_WIDTH;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSAL_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SAMPLES = 2'd2;

    // Reset values of the registers
    localparam logic [LEVEL_WIDTH-1:0]  TRIGGER_RESET  = 15'd4000;
    localparam logic [LEVEL_WIDTH-1:0]  REVERSAL_RESET = 15'd500;
    localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET   = 8'd12;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_rate;
    typedef logic [SAMPLE_WIDTH-1:0]        t_mag;
    typedef logic [FACE_WIDTH-1:0]          t_face;

    typedef struct packed {
        t_rate rate_x;
        t_rate rate_y;
        t_rate rate_z;
        t_face side_first;
        t_face side_second;
        t_face side_third;
    } t_sample;

    typedef struct packed {
        t_face face;
        logic [2:0] tone;
        logic       direction;
    } t_result;

    // Outcome of one axis check
    typedef struct packed {
        logic    hit;
        t_result res;
    } t_hit;

    // Exact magnitude; the most negative value maps to 2^(W-1) without wrap
    function automatic t_mag mag(input t_rate v);
        t_mag u;
        u = t_mag'(v);
        return v[SAMPLE_WIDTH-1] ? (~u + t_mag'(1)) : u;
    endfunction

    // Magnitude strictly above a level
    function automatic logic above(input t_rate v, input logic [LEVEL_WIDTH-1:0] lvl);
        return CMP_WIDTH'(mag(v)) > CMP_WIDTH'(lvl);
    endfunction

endpackage

// ===== design/gyro_flick_reversal_detector.sv =====
// Gyro flick reversal detector.
// Input channel: one item per gyro sample (three signed rates plus three face
// numbers), valid/ready. Output channel: a face, tone and direction item each
// time a stored strong sample is followed, inside the window, by a reversed
// sample on an axis whose face is held. Most samples give no output item.
// Configuration: write enable, register index and data; write only when idle.
// The input register holds an item, and its result, if any, is loaded into the
// output register when the item advances. Throughput: one item per cycle while
// the output register is free or being taken, set by the single compare stage
// between the input and output registers.
// When the receiver stalls with a result waiting, the input register holds
// its item and o_in_ready drops once that register is occupied; items that
// give no result still wait behind the full output register.
// Reset clears the window (idle), the stored sample and faces, both valid
// flags, and loads trigger 4000, reversal 500 and window 12.
module gyro_flick_reversal_detector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  gfr_pkg::t_sample                    i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output gfr_pkg::t_result                    o_out_item,
    input  logic                                i_cfg_we,
    input  logic [gfr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gfr_pkg::CFG_WIDTH-1:0]       i_cfg_data
);
    import gfr_pkg::*;

    logic [LEVEL_WIDTH-1:0]  r_trigger;
    logic [LEVEL_WIDTH-1:0]  r_reversal;
    logic [WINDOW_WIDTH-1:0] r_window;

    logic    r_in_valid;
    t_sample r_in;
    logic    r_out_valid;
    t_result r_out;

    logic                    r_open;
    t_rate                   r_start_x;
    t_rate                   r_start_y;
    t_rate                   r_start_z;
    t_face                   r_held_first;
    t_face                   r_held_second;
    t_face                   r_held_third;
    logic [WINDOW_WIDTH-1:0] r_seen;

    logic                    n_open;
    logic [WINDOW_WIDTH-1:0] n_seen;
    logic                    n_store;
    logic                    advance;
    logic                    trig;
    logic                    found;
    t_result                 found_res;
    logic [WINDOW_WIDTH-1:0] seen_inc;
    logic [WINDOW_WIDTH-1:0] limit;
    t_hit                    hit_x;
    t_hit                    hit_y;
    t_hit                    hit_z;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger  <= TRIGGER_RESET;
            r_reversal <= REVERSAL_RESET;
            r_window   <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TRIGGER_LEVEL:  r_trigger  <= i_cfg_data[LEVEL_WIDTH-1:0];
                REG_REVERSAL_LEVEL: r_reversal <= i_cfg_data[LEVEL_WIDTH-1:0];
                REG_WINDOW_SAMPLES: r_window   <= i_cfg_data[WINDOW_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Capture the incoming item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Check each axis against the stored trigger sample
    gfr_axis #(.FIRST_FACE(3'd1), .SECOND_FACE(3'd3), .FIRST_TONE(3'd0), .FIRST_POS(1'b1))
    u_axis_x (
        .i_start(r_start_x), .i_now(r_in.rate_x),
        .i_trigger_level(r_trigger), .i_reversal_level(r_reversal),
        .i_held_first(r_held_first), .i_held_second(r_held_second),
        .i_held_third(r_held_third), .o_hit(hit_x)
    );

    gfr_axis #(.FIRST_FACE(3'd2), .SECOND_FACE(3'd4), .FIRST_TONE(3'd2), .FIRST_POS(1'b1))
    u_axis_y (
        .i_start(r_start_y), .i_now(r_in.rate_y),
        .i_trigger_level(r_trigger), .i_reversal_level(r_reversal),
        .i_held_first(r_held_first), .i_held_second(r_held_second),
        .i_held_third(r_held_third), .o_hit(hit_y)
    );

    gfr_axis #(.FIRST_FACE(3'd0), .SECOND_FACE(3'd5), .FIRST_TONE(3'd4), .FIRST_POS(1'b0))
    u_axis_z (
        .i_start(r_start_z), .i_now(r_in.rate_z),
        .i_trigger_level(r_trigger), .i_reversal_level(r_reversal),
        .i_held_first(r_held_first), .i_held_second(r_held_second),
        .i_held_third(r_held_third), .o_hit(hit_z)
    );

    // Take the first qualifying axis in x, y, z order
    always_comb begin
        found     = r_open && (hit_x.hit || hit_y.hit || hit_z.hit);
        found_res = hit_z.res;
        if (hit_x.hit) begin
            found_res = hit_x.res;
        end else if (hit_y.hit) begin
            found_res = hit_y.res;
        end
    end

    assign trig = above(r_in.rate_x, r_trigger) || above(r_in.rate_y, r_trigger)
               || above(r_in.rate_z, r_trigger);
    assign seen_inc = r_seen + WINDOW_WIDTH'(1);
    assign limit    = (r_window == '0) ? WINDOW_WIDTH'(1) : r_window;

    // Next window state
    always_comb begin
        n_open  = r_open;
        n_seen  = r_seen;
        n_store = 1'b0;
        if (advance) begin
            if (!r_open) begin
                if (trig) begin
                    n_open  = 1'b1;
                    n_seen  = '0;
                    n_store = 1'b1;
                end
            end else if (found || (seen_inc >= limit)) begin
                n_open = 1'b0;
                n_seen = '0;
            end else begin
                n_seen = seen_inc;
            end
        end
    end

    // Advance window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open        <= 1'b0;
            r_seen        <= '0;
            r_start_x     <= '0;
            r_start_y     <= '0;
            r_start_z     <= '0;
            r_held_first  <= '0;
            r_held_second <= '0;
            r_held_third  <= '0;
        end else begin
            r_open <= n_open;
            r_seen <= n_seen;
            if (n_store) begin
                r_start_x     <= r_in.rate_x;
                r_start_y     <= r_in.rate_y;
                r_start_z     <= r_in.rate_z;
                r_held_first  <= r_in.side_first;
                r_held_second <= r_in.side_second;
                r_held_third  <= r_in.side_third;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && found) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && found) begin
            r_out <= found_res;
        end
    end

endmodule

// ===== design/gfr_axis.sv =====
module gfr_axis #(
    parameter logic [2:0] FIRST_FACE  = 3'd1,
    parameter logic [2:0] SECOND_FACE = 3'd3,
    parameter logic [2:0] FIRST_TONE  = 3'd0,
    parameter logic       FIRST_POS   = 1'b1
) (
    input  gfr_pkg::t_rate  i_start,
    input  gfr_pkg::t_rate  i_now,
    input  logic [gfr_pkg::LEVEL_WIDTH-1:0] i_trigger_level,
    input  logic [gfr_pkg::LEVEL_WIDTH-1:0] i_reversal_level,
    input  gfr_pkg::t_face  i_held_first,
    input  gfr_pkg::t_face  i_held_second,
    input  gfr_pkg::t_face  i_held_third,
    output gfr_pkg::t_hit   o_hit
);
    import gfr_pkg::*;

    logic start_pos;
    logic start_neg;
    logic now_pos;
    logic now_neg;
    logic rev;
    logic has_first;
    logic has_second;

    // Sign of stored and new samples
    assign start_neg = i_start[SAMPLE_WIDTH-1];
    assign start_pos = !start_neg && (i_start != '0);
    assign now_neg   = i_now[SAMPLE_WIDTH-1];
    assign now_pos   = !now_neg && (i_now != '0);

    // Strict sign reversal from a strong stored sample
    assign rev = above(i_start, i_trigger_level)
              && ((start_pos && now_neg) || (start_neg && now_pos))
              && above(i_now, i_reversal_level);

    assign has_first  = (i_held_first == FIRST_FACE) || (i_held_second == FIRST_FACE)
                     || (i_held_third == FIRST_FACE);
    assign has_second = (i_held_first == SECOND_FACE) || (i_held_second == SECOND_FACE)
                     || (i_held_third == SECOND_FACE);

    // Pick the face pair member, first one preferred
    always_comb begin
        o_hit = '0;
        if (rev && has_first) begin
            o_hit.hit           = 1'b1;
            o_hit.res.face      = FIRST_FACE;
            o_hit.res.tone      = FIRST_TONE;
            o_hit.res.direction = FIRST_POS ? start_pos : start_neg;
        end else if (rev && has_second) begin
            o_hit.hit           = 1'b1;
            o_hit.res.face      = SECOND_FACE;
            o_hit.res.tone      = FIRST_TONE + 3'd1;
            o_hit.res.direction = FIRST_POS ? start_neg : start_pos;
        end
    end

endmodule
